/* hdl/entab_pkg.sv */
// shared types, character codes and tab stop helpers for the entab block
// no dependencies; imported by every entab module
`default_nettype none

package entab_pkg;

   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;

   localparam logic [5:0] FIRST_STOP_RESET    = 6'd8;
   localparam logic [5:0] STOP_INTERVAL_RESET = 6'd8;

   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // csr register indexes
   localparam logic CSR_FIRST_STOP    = 1'b0;
   localparam logic CSR_STOP_INTERVAL = 1'b1;

   // one queued command: a run of spaces, optionally followed by one byte
   typedef struct packed {
      logic [5:0] spaces;
      logic       has_char;
      logic [7:0] ch_byte;
   } entab_cmd_type;

   function automatic logic [5:0] eff_interval(input logic [5:0] iv);
      return (iv == 6'd0) ? 6'd1 : iv;
   endfunction

   // columns from column 1 to the first stop
   function automatic logic [5:0] line_start_dist(input logic [5:0] fs,
                                                  input logic [5:0] iv);
      logic [5:0] n;
      n = eff_interval(iv);
      if (fs > 6'd1) begin
         return fs - 6'd1;
      end else if (fs == 6'd1) begin
         return n;
      end else begin
         return (n == 6'd1) ? 6'd1 : n - 6'd1;
      end
   endfunction

endpackage

`default_nettype wire

/* hdl/entab_front.sv */
// front end: holds the tab stop registers and column state, classifies each
// request and pushes a command to the queue; uses entab_pkg
`default_nettype none

module entab_front
   import entab_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          csr_wr_en,
   input  wire logic          csr_index,
   input  wire logic [5:0]    csr_wdata,
   input  wire logic          req_valid,
   input  wire logic [7:0]    req_in_byte,
   input  wire logic          req_flush,
   input  wire logic          q_full,
   output logic               q_push,
   output entab_cmd_type      q_cmd
);

   logic [5:0] first_stop_ff, first_stop_in;
   logic [5:0] stop_interval_ff, stop_interval_in;
   logic [5:0] cols_to_stop_ff, cols_to_stop_in;
   logic [5:0] pending_ff, pending_in;
   logic       accept;

   assign accept = req_valid && !q_full;

   always_comb begin
      first_stop_in    = first_stop_ff;
      stop_interval_in = stop_interval_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_FIRST_STOP:    first_stop_in    = csr_wdata;
            CSR_STOP_INTERVAL: stop_interval_in = csr_wdata;
            default:           first_stop_in    = first_stop_ff;
         endcase
      end
   end

   always_comb begin
      cols_to_stop_in = cols_to_stop_ff;
      pending_in      = pending_ff;
      q_push          = 1'b0;
      q_cmd.spaces    = pending_ff;
      q_cmd.has_char  = 1'b1;
      q_cmd.ch_byte   = req_in_byte;
      if (accept) begin
         if (req_flush) begin
            q_push         = (pending_ff != 6'd0);
            q_cmd.has_char = 1'b0;
            pending_in     = 6'd0;
         end else if (req_in_byte == CH_SPACE) begin
            if (cols_to_stop_ff <= 6'd1) begin
               // blank lands on a stop: the whole run becomes one tab
               q_push          = 1'b1;
               q_cmd.spaces    = 6'd0;
               q_cmd.ch_byte   = CH_TAB;
               pending_in      = 6'd0;
               cols_to_stop_in = eff_interval(stop_interval_ff);
            end else begin
               cols_to_stop_in = cols_to_stop_ff - 6'd1;
               pending_in      = 6'(pending_ff + 6'd1);
            end
         end else begin
            q_push     = 1'b1;
            pending_in = 6'd0;
            if (req_in_byte == CH_NEWLINE) begin
               cols_to_stop_in = line_start_dist(first_stop_ff, stop_interval_ff);
            end else if (cols_to_stop_ff <= 6'd1) begin
               cols_to_stop_in = eff_interval(stop_interval_ff);
            end else begin
               cols_to_stop_in = cols_to_stop_ff - 6'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_stop_ff    <= FIRST_STOP_RESET;
         stop_interval_ff <= STOP_INTERVAL_RESET;
         cols_to_stop_ff  <= line_start_dist(FIRST_STOP_RESET, STOP_INTERVAL_RESET);
         pending_ff       <= 6'd0;
      end else begin
         first_stop_ff    <= first_stop_in;
         stop_interval_ff <= stop_interval_in;
         cols_to_stop_ff  <= cols_to_stop_in;
         pending_ff       <= pending_in;
      end
   end

   // distance to the next stop is never zero
   a_cols_nonzero: assert property (@(posedge clock) disable iff (reset)
      cols_to_stop_ff != 6'd0)
      else $error("cols_to_stop reached zero");

   // pending run always stays below the stop distance, so it never fills 6 bits
   a_pending_bound: assert property (@(posedge clock) disable iff (reset)
      pending_ff != 6'd63)
      else $error("pending blank count overflow");

endmodule

`default_nettype wire

/* hdl/entab_queue.sv */
// short command queue between the front and back ends
// uses entab_pkg for the command type
`default_nettype none

module entab_queue
   import entab_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  entab_cmd_type      push_cmd,
   input  wire logic          pop,
   output logic               full,
   output logic               empty,
   output entab_cmd_type      head_cmd
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entab_cmd_type      slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign head_cmd = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      !(push && full) && !(pop && empty))
      else $error("queue pushed when full or popped when empty");

endmodule

`default_nettype wire

/* hdl/entab_back.sv */
// back end: expands queued commands into output bytes through a registered
// output stage; uses entab_pkg
`default_nettype none

module entab_back
   import entab_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          q_empty,
   input  entab_cmd_type      q_head,
   output logic               q_pop,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output logic [7:0]         rsp_out_byte,
   output logic               rsp_last
);

   logic          busy_ff, busy_in;
   entab_cmd_type cur_ff, cur_in;
   entab_cmd_type src;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_out_byte_ff, rsp_out_byte_in;
   logic          rsp_last_ff, rsp_last_in;
   logic          out_ready;
   logic          emit;
   logic          done;

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign emit      = out_ready && (busy_ff || !q_empty);
   assign q_pop     = emit && !busy_ff;
   // a command in progress takes priority over the queue head
   assign src       = busy_ff ? cur_ff : q_head;

   always_comb begin
      busy_in         = busy_ff;
      cur_in          = cur_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_out_byte_in = rsp_out_byte_ff;
      rsp_last_in     = rsp_last_ff;
      done            = 1'b1;
      if (out_ready) begin
         rsp_valid_in = emit;
      end
      if (emit) begin
         if (src.spaces != 6'd0) begin
            done            = (src.spaces == 6'd1) && !src.has_char;
            rsp_out_byte_in = CH_SPACE;
         end else begin
            rsp_out_byte_in = src.ch_byte;
         end
         rsp_last_in     = done;
         busy_in         = !done;
         cur_in.spaces   = src.spaces - 6'd1;
         cur_in.has_char = src.has_char;
         cur_in.ch_byte  = src.ch_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff          <= cur_in;
      rsp_out_byte_ff <= rsp_out_byte_in;
      rsp_last_ff     <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_out_byte_ff;
   assign rsp_last     = rsp_last_ff;

   // a held command always has something left to send
   a_busy_has_work: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (cur_ff.spaces != 6'd0 || cur_ff.has_char))
      else $error("back end busy with an empty command");

endmodule

`default_nettype wire

/* hdl/entab_blank_to_tab_stream.sv */
// top level of the entab block: front end, command queue and back end
// uses entab_pkg, entab_front, entab_queue, entab_back
`default_nettype none

// Replaces runs of blanks in a byte stream with tabs and spaces that keep the
// same spacing. Tab stops sit at csr register 0 (first stop column) and every
// csr register 1 columns after it; columns restart at 1 after a newline.
// Requests are taken one per cycle while the command queue has room; a
// request that ends a blank run issues n pending spaces plus its own byte,
// n+1 responses at one per cycle while rsp_stall is low, from the back end's
// output register, so the queue (QUEUE_DEPTH commands) absorbs the burst. A
// lone blank that does not reach a stop gives no response; a flush emits
// pending blanks as spaces. With the back end idle, the first response of a
// request passes the queue and the output register. rsp_last marks the final
// response of each request. Write the csr registers only while the block is
// idle; new values take effect at the next stop or line.

module entab_blank_to_tab_stream
   import entab_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_wr_en,
   input  wire logic       csr_index,
   input  wire logic [5:0] csr_wdata,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       req_flush,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_last
);

   logic          q_push;
   logic          q_pop;
   logic          q_full;
   logic          q_empty;
   entab_cmd_type q_cmd;
   entab_cmd_type q_head;

   assign req_stall = q_full;

   entab_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_valid   (req_valid),
      .req_in_byte (req_in_byte),
      .req_flush   (req_flush),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_cmd       (q_cmd)
   );

   entab_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_cmd),
      .pop      (q_pop),
      .full     (q_full),
      .empty    (q_empty),
      .head_cmd (q_head)
   );

   entab_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_empty      (q_empty),
      .q_head       (q_head),
      .q_pop        (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last)
   );

endmodule

`default_nettype wire

/* test/entab_blank_to_tab_stream_tb.sv */
`timescale 1ns / 1ps
// self-checking testbench for entab_blank_to_tab_stream: directed and random
// byte streams under several tab stop settings, checked by an in-bench scoreboard
// depends on entab_pkg and the entab rtl

module entab_blank_to_tab_stream_tb
   import entab_pkg::*;
();

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int SETTLE_CYCLES  = 8;
   localparam int PHASE_ITEMS    = 60;
   localparam int NUM_PHASES     = 8;

   typedef struct {
      logic [7:0] ch;
      logic       last;
   } out_char_type;

   // tracks tab stop state and queues the characters each request should produce
   class entab_scoreboard;
      logic [5:0]   first_stop;
      logic [5:0]   stop_interval;
      logic [5:0]   cols_left;
      logic [5:0]   blanks_held;
      out_char_type expected_chars[$];
      int           errors;
      int           requests_taken;
      int           responses_seen;

      function new();
         first_stop     = FIRST_STOP_RESET;
         stop_interval  = STOP_INTERVAL_RESET;
         cols_left      = start_of_line();
         blanks_held    = 6'd0;
         errors         = 0;
         requests_taken = 0;
         responses_seen = 0;
      endfunction

      function logic [5:0] step_interval();
         return (stop_interval == 6'd0) ? 6'd1 : stop_interval;
      endfunction

      // distance from column 1 to the first stop of a line
      function logic [5:0] start_of_line();
         logic [5:0] n;
         n = step_interval();
         if (first_stop == 6'd0) begin
            // stops at multiples of the interval
            return (n == 6'd1) ? 6'd1 : n - 6'd1;
         end
         return (first_stop == 6'd1) ? n : first_stop - 6'd1;
      endfunction

      function void write_reg(logic idx, logic [5:0] val);
         if (idx == CSR_FIRST_STOP) begin
            first_stop = val;
         end else begin
            stop_interval = val;
         end
      endfunction

      function int outstanding();
         return expected_chars.size();
      endfunction

      function void take_request(logic [7:0] b, logic fl);
         logic [7:0] burst[$];
         requests_taken++;
         if (!fl && b == CH_SPACE) begin
            if (cols_left <= 6'd1) begin
               burst.push_back(CH_TAB);
               blanks_held = 6'd0;
               cols_left   = step_interval();
            end else begin
               cols_left--;
               blanks_held++;
            end
         end else begin
            repeat (blanks_held) burst.push_back(CH_SPACE);
            blanks_held = 6'd0;
            if (!fl) begin
               burst.push_back(b);
               if (b == CH_NEWLINE) begin
                  cols_left = start_of_line();
               end else if (cols_left <= 6'd1) begin
                  cols_left = step_interval();
               end else begin
                  cols_left--;
               end
            end
         end
         foreach (burst[i]) begin
            expected_chars.push_back('{ch: burst[i], last: (i == burst.size() - 1)});
         end
      endfunction

      task flag_error(string msg);
         errors++;
         $display("mismatch at %0t: %s", $time, msg);
      endtask

      task check_char(logic [7:0] b, logic lst);
         out_char_type want;
         responses_seen++;
         if (expected_chars.size() == 0) begin
            flag_error($sformatf("response 0x%02h with nothing expected", b));
            return;
         end
         want = expected_chars.pop_front();
         if (b !== want.ch) begin
            flag_error($sformatf("out_byte 0x%02h, expected 0x%02h", b, want.ch));
         end
         if (lst !== want.last) begin
            flag_error($sformatf("last %b, expected %b on 0x%02h", lst, want.last, want.ch));
         end
      endtask
   endclass

   logic       clock        = 1'b0;
   logic       reset        = 1'b1;
   logic       csr_wr_en    = 1'b0;
   logic       csr_index    = CSR_FIRST_STOP;
   logic [5:0] csr_wdata    = 6'd0;
   logic       req_valid    = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_byte  = 8'h00;
   logic       req_flush    = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall    = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_last;

   entab_scoreboard sb = new();
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int requests_sent = 0;
   int idle_cycles   = 0;

   entab_blank_to_tab_stream u_dut (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_in_byte  (req_in_byte),
      .req_flush    (req_flush),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_stall = ($urandom_range(99) < recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            sb.take_request(req_in_byte, req_flush);
         end
         if (rsp_valid && !rsp_stall) begin
            sb.check_char(rsp_out_byte, rsp_last);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles, %0d responses outstanding",
                  idle_cycles, sb.outstanding());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_request(input logic [7:0] b, input logic fl);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid   = 1'b1;
      req_in_byte = b;
      req_flush   = fl;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      requests_sent++;
   endtask

   // lets the block go idle so the stop registers can be rewritten
   task automatic settle();
      req_valid = 1'b0;
      while (sb.outstanding() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [5:0] val);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_wr_en = 1'b0;
      sb.write_reg(idx, val);
   endtask

   // mostly text-like pieces: blank runs, printable bytes, line ends, tabs
   task automatic send_segment();
      int r;
      int n;
      r = $urandom_range(99);
      if (r < 38) begin
         n = ($urandom_range(3) == 0) ? $urandom_range(70, 1) : $urandom_range(10, 1);
         repeat (n) send_request(CH_SPACE, 1'b0);
      end else if (r < 66) begin
         send_request(8'($urandom_range(8'h7e, 8'h21)), 1'b0);
      end else if (r < 74) begin
         send_request(CH_NEWLINE, 1'b0);
      end else if (r < 81) begin
         send_request(CH_TAB, 1'b0);
      end else if (r < 87) begin
         send_request(8'($urandom_range(255)), 1'b1);
      end else begin
         send_request(8'($urandom_range(255)), 1'b0);
      end
   endtask

   initial begin
      logic [5:0] fs;
      logic [5:0] iv;
      int         target;

      repeat (9) @(negedge clock);
      reset = 1'b0;
      send_idle_pct = 29;
      recv_idle_pct = 55;

      // default stops every 8 columns
      send_request(8'h61, 1'b0);
      repeat (6) send_request(CH_SPACE, 1'b0);   // last blank lands on the stop
      send_request(CH_SPACE, 1'b0);              // held as a pending blank, short of a stop
      send_request(8'hff, 1'b1);                 // flush emits it as a space
      send_request(8'h00, 1'b1);                 // flush with nothing held
      send_request(CH_TAB, 1'b0);
      send_request(CH_SPACE, 1'b0);
      send_request(CH_SPACE, 1'b0);
      send_request(8'hff, 1'b0);
      send_request(8'h00, 1'b0);
      send_request(CH_NEWLINE, 1'b0);
      settle();
      // zero interval and zero first stop: a stop on every column
      write_csr(CSR_FIRST_STOP, 6'd0);
      write_csr(CSR_STOP_INTERVAL, 6'd0);
      send_request(CH_NEWLINE, 1'b0);
      send_request(CH_SPACE, 1'b0);
      send_request(8'h78, 1'b0);
      settle();
      write_csr(CSR_FIRST_STOP, 6'd1);
      write_csr(CSR_STOP_INTERVAL, 6'd2);
      send_request(CH_NEWLINE, 1'b0);
      send_request(CH_SPACE, 1'b0);
      send_request(CH_SPACE, 1'b0);
      send_request(8'h55, 1'b1);

      for (int p = 0; p < NUM_PHASES; p++) begin
         settle();
         case (p)
            0: begin fs = 6'd8;  iv = 6'd8;  end
            1: begin fs = 6'd1;  iv = 6'd1;  end
            2: begin fs = 6'd63; iv = 6'd63; end
            3: begin fs = 6'd0;  iv = 6'd0;  end
            4: begin fs = 6'd0;  iv = 6'd63; end
            5: begin fs = 6'd63; iv = 6'd1;  end
            6: begin fs = 6'd1;  iv = 6'd63; end
            default: begin
               fs = 6'($urandom_range(63));
               iv = 6'($urandom_range(63));
            end
         endcase
         write_csr(CSR_FIRST_STOP, fs);
         write_csr(CSR_STOP_INTERVAL, iv);
         if (p < 3) begin
            send_idle_pct = 29;
            recv_idle_pct = 55;
         end else if (p < 6) begin
            send_idle_pct = 55;
            recv_idle_pct = 29;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         target = requests_sent + PHASE_ITEMS;
         while (requests_sent < target) send_segment();
      end

      send_request(8'h00, 1'b1);
      settle();

      $display("sent %0d requests, checked %0d responses", sb.requests_taken,
               sb.responses_seen);
      $display("stop settings covered: defaults, zero, one, 63 and a random pair");
      if (sb.errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d mismatches", sb.errors);
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
